// ===== rtl/rba_pkg.sv =====
`default_nettype none
package rba_pkg;

	localparam int KIND_W   = 3;
	localparam int IDX_W    = 10;
	localparam int FHASH_W  = 64;
	localparam int STAT_W   = 3;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 80;

	// input tdata layout
	localparam int S_IDX_LO  = 0;
	localparam int S_HASH_LO = S_IDX_LO + IDX_W;

	// output tdata layout
	localparam int M_GRANT_LO = 0;
	localparam int M_EVV_BIT  = M_GRANT_LO + IDX_W;
	localparam int M_EVH_LO   = M_EVV_BIT + 1;
	localparam int M_FREE_BIT = M_EVH_LO + FHASH_W;
	localparam int M_USED_W   = M_FREE_BIT + 1;

	localparam logic [KIND_W-1:0] K_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] K_ADD_REF = 3'd1;
	localparam logic [KIND_W-1:0] K_RELEASE = 3'd2;
	localparam logic [KIND_W-1:0] K_TAKE    = 3'd3;
	localparam logic [KIND_W-1:0] K_SET_HASH = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FREE  = 3'd3;
	localparam logic [STAT_W-1:0] ST_SATURATED = 3'd4;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic exec;
		logic push;
		logic load_out;
	} rba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic push_now;
	} rba_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rba_ram.sv =====
`default_nettype none
module rba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/rba_ctrl.sv =====
`default_nettype none
module rba_ctrl
	import rba_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_ready,
	output      logic     out_valid,
	input  wire logic     out_ready,
	input  wire rba_sts_t sts,
	output      rba_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_PUSH,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.clr_step = (state_q == S_CLEAR);
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.push     = (state_q == S_PUSH);
		cmd.load_out = (state_q == S_RESP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= sts.push_now ? S_PUSH : S_RESP;
				end
				S_PUSH: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rba_dp.sv =====
`default_nettype none
module rba_dp
	import rba_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int REF_WIDTH  = 16,
	parameter int HASH_WIDTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rba_cmd_t           cmd,
	output      rba_sts_t           sts,
	input  wire logic [KIND_W-1:0]  in_kind,
	input  wire logic [IDX_W-1:0]   in_idx,
	input  wire logic [FHASH_W-1:0] in_hash,
	output      logic [STAT_W-1:0]  out_status,
	output      logic [IDX_W-1:0]   out_granted,
	output      logic               out_ev_valid,
	output      logic [FHASH_W-1:0] out_ev_hash,
	output      logic               out_became_free
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int IW = HASH_WIDTH + REF_WIDTH + 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

	// list and op registers
	logic [AW-1:0]         head_q, tail_q, old_head_q, clr_cnt_q, id_q;
	logic [CW-1:0]         count_q;
	logic [KIND_W-1:0]     kind_q;
	logic                  in_range_q;
	logic [HASH_WIDTH-1:0] hash_q;

	// pending result
	logic [STAT_W-1:0]     res_status_q;
	logic                  res_ev_valid_q, res_became_q;
	logic [HASH_WIDTH-1:0] res_ev_hash_q;

	// RAM ports
	logic          prev_we, next_we, info_we;
	logic [AW-1:0] prev_wa, next_wa, info_wa, rd_addr;
	logic [AW-1:0] prev_wd, next_wd, prev_rd, next_rd;
	logic [IW-1:0] info_wd, info_rd;

	logic                  rd_free;
	logic [REF_WIDTH-1:0]  rd_ref, ref_dec;
	logic [HASH_WIDTH-1:0] rd_hash;

	// execution decisions
	logic                  do_unlink, do_push, do_info;
	logic [IW-1:0]         info_new;
	logic [STAT_W-1:0]     ex_status;
	logic                  ex_ev_valid;

	assign rd_addr = (in_kind == K_ALLOC) ? tail_q : AW'(in_idx);

	assign rd_free = info_rd[0];
	assign rd_ref  = info_rd[REF_WIDTH:1];
	assign rd_hash = info_rd[IW-1:REF_WIDTH+1];
	assign ref_dec = rd_ref - REF_WIDTH'(1);

	always_comb begin
		do_unlink   = 1'b0;
		do_push     = 1'b0;
		do_info     = 1'b0;
		info_new    = info_rd;
		ex_status   = ST_OK;
		ex_ev_valid = 1'b0;
		if (kind_q == K_ALLOC) begin
			if (count_q == '0) begin
				ex_status = ST_EMPTY;
			end else begin
				do_unlink   = 1'b1;
				do_info     = 1'b1;
				info_new    = {{HASH_WIDTH{1'b0}}, REF_WIDTH'(1), 1'b0};
				ex_ev_valid = (rd_hash != '0);
			end
		end else if (in_range_q) begin
			unique case (kind_q)
				K_ADD_REF: begin
					if (rd_ref == {REF_WIDTH{1'b1}}) begin
						ex_status = ST_SATURATED;
					end else begin
						do_info  = 1'b1;
						info_new = {rd_hash, rd_ref + REF_WIDTH'(1), rd_free};
					end
				end
				K_RELEASE: begin
					if (rd_ref == '0) begin
						ex_status = ST_UNDERFLOW;
					end else begin
						do_info = 1'b1;
						do_push = (ref_dec == '0) && !rd_free;
						info_new = {rd_hash, ref_dec, rd_free || do_push};
					end
				end
				K_TAKE: begin
					if (!rd_free) begin
						ex_status = ST_NOT_FREE;
					end else begin
						do_unlink = 1'b1;
						do_info   = 1'b1;
						info_new  = {rd_hash, REF_WIDTH'(1), 1'b0};
					end
				end
				K_SET_HASH: begin
					do_info  = 1'b1;
					info_new = {hash_q, rd_ref, rd_free};
				end
				default: ;
			endcase
		end
	end

	assign sts = '{clr_last: (clr_cnt_q == LAST), push_now: do_push && (count_q != '0)};

	// write port selection
	always_comb begin
		prev_we = 1'b0;
		prev_wa = id_q;
		prev_wd = '0;
		next_we = 1'b0;
		next_wa = id_q;
		next_wd = head_q;
		info_we = 1'b0;
		info_wa = id_q;
		info_wd = info_new;
		priority if (cmd.clr_step) begin
			prev_we = 1'b1;
			prev_wa = clr_cnt_q;
			prev_wd = (clr_cnt_q == '0) ? '0 : clr_cnt_q - AW'(1);
			next_we = 1'b1;
			next_wa = clr_cnt_q;
			next_wd = (clr_cnt_q == LAST) ? '0 : clr_cnt_q + AW'(1);
			info_we = 1'b1;
			info_wa = clr_cnt_q;
			info_wd = {{(IW-1){1'b0}}, 1'b1};
		end else if (cmd.exec) begin
			info_we = do_info;
			if (do_unlink) begin
				prev_we = (id_q != tail_q);
				prev_wa = next_rd;
				prev_wd = prev_rd;
				next_we = (id_q != head_q);
				next_wa = prev_rd;
				next_wd = next_rd;
			end else if (do_push) begin
				prev_we = 1'b1;
				next_we = (count_q != '0);
			end
		end else if (cmd.push) begin
			prev_we = 1'b1;
			prev_wa = old_head_q;
			prev_wd = id_q;
		end
	end

	rba_ram #(.WIDTH(AW), .DEPTH(NUM_BLOCKS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(rd_addr), .rdata(prev_rd)
	);

	rba_ram #(.WIDTH(AW), .DEPTH(NUM_BLOCKS)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(rd_addr), .rdata(next_rd)
	);

	rba_ram #(.WIDTH(IW), .DEPTH(NUM_BLOCKS)) u_info (
		.clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
		.raddr(rd_addr), .rdata(info_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= LAST;
			count_q   <= CW'(NUM_BLOCKS);
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.exec && do_unlink) begin
				if (id_q == head_q) begin
					head_q <= next_rd;
				end
				if (id_q == tail_q) begin
					tail_q <= prev_rd;
				end
				count_q <= count_q - CW'(1);
			end else if (cmd.exec && do_push) begin
				if (count_q == '0) begin
					tail_q <= id_q;
				end
				head_q  <= id_q;
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q     <= in_kind;
			id_q       <= rd_addr;
			in_range_q <= (32'(in_idx) < NUM_BLOCKS);
			hash_q     <= in_hash[HASH_WIDTH-1:0];
		end
		if (cmd.exec) begin
			old_head_q     <= head_q;
			res_status_q   <= ex_status;
			res_ev_valid_q <= ex_ev_valid;
			res_ev_hash_q  <= ex_ev_valid ? rd_hash : '0;
			res_became_q   <= do_push;
		end
		if (cmd.load_out) begin
			out_status      <= res_status_q;
			out_granted     <= (kind_q == K_ALLOC && res_status_q == ST_OK) ?
				IDX_W'(id_q) : '0;
			out_ev_valid    <= res_ev_valid_q;
			out_ev_hash     <= FHASH_W'(res_ev_hash_q);
			out_became_free <= res_became_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/refcounted_block_allocator_lru.sv =====
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   block_index[9:0], hash_value[73:10], zero pad        kind[2:0]
// m_axis    out  granted_block[9:0], evicted_valid[10],               status[2:0]
//                evicted_hash[74:11], became_free[75], zero pad
//
// Each transaction passes through accept, execute and load-the-result steps; a
// release that returns a block to a non-empty free list adds a push step (the
// prev-link RAM port takes one write a cycle).
// The result register holds one finished item while the next is accepted; a result
// still stalled on m_axis_tready holds the next one in the load cycle. After reset a
// clearing pass initializes every entry of the link and block RAMs;
// s_axis_tready stays low until it ends.
`default_nettype none
module refcounted_block_allocator_lru
	import rba_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int REF_WIDTH  = 16,
	parameter int HASH_WIDTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output      logic                s_axis_tready,
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // block_index, hash_value
	input  wire logic [KIND_W-1:0]   s_axis_tuser,  // kind
	output      logic                m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output      logic [M_DATA_W-1:0] m_axis_tdata,  // granted_block, evicted_valid,
	                                                // evicted_hash, became_free
	output      logic [STAT_W-1:0]   m_axis_tuser   // status
);

	rba_cmd_t cmd;
	rba_sts_t sts;

	logic [IDX_W-1:0]   granted;
	logic               ev_valid, became_free;
	logic [FHASH_W-1:0] ev_hash;

	rba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.REF_WIDTH  (REF_WIDTH),
		.HASH_WIDTH (HASH_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_kind         (s_axis_tuser),
		.in_idx          (s_axis_tdata[S_IDX_LO +: IDX_W]),
		.in_hash         (s_axis_tdata[S_HASH_LO +: FHASH_W]),
		.out_status      (m_axis_tuser),
		.out_granted     (granted),
		.out_ev_valid    (ev_valid),
		.out_ev_hash     (ev_hash),
		.out_became_free (became_free)
	);

	assign m_axis_tdata = {{(M_DATA_W-M_USED_W){1'b0}}, became_free, ev_hash, ev_valid,
		granted};

endmodule
`default_nettype wire

// ===== rtl/rba_checker.sv =====
`default_nettype none
module rba_checker
	import rba_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [M_DATA_W-1:0] m_axis_tdata,
	input wire logic [STAT_W-1:0]   m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[M_USED_W-1:0] == '0)
		else $error("failed transaction carries data");

	a_free_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[M_FREE_BIT] |->
			m_axis_tuser == ST_OK && !m_axis_tdata[M_EVV_BIT])
		else $error("became_free with eviction or error");

	a_evict_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[M_EVV_BIT] |-> m_axis_tdata[M_EVH_LO +: FHASH_W] != '0)
		else $error("eviction reports zero hash");

endmodule

bind refcounted_block_allocator_lru rba_checker u_rba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== tb/refcounted_block_allocator_lru_test.sv =====
`timescale 1ns / 1ps
module refcounted_block_allocator_lru_test;
	import rba_pkg::*;

	localparam int NBLK    = 1024;
	localparam int REF_MAX = 65535;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [IDX_W-1:0]   granted;
		logic               ev_valid;
		logic [FHASH_W-1:0] ev_hash;
		logic               became_free;
	} pool_result_t;

	class pool_scoreboard;
		logic [IDX_W-1:0]   prev_link [NBLK];
		logic [IDX_W-1:0]   next_link [NBLK];
		logic [IDX_W-1:0]   head, tail;
		int                 n_free;
		bit                 is_free [NBLK];
		int                 refcnt [NBLK];
		logic [FHASH_W-1:0] tag [NBLK];
		pool_result_t       pending [$];
		int                 errors;

		function new();
			for (int i = 0; i < NBLK; i++) begin
				prev_link[i] = (i == 0) ? '0 : IDX_W'(i - 1);
				next_link[i] = (i + 1 < NBLK) ? IDX_W'(i + 1) : '0;
				is_free[i] = 1;
				refcnt[i] = 0;
				tag[i] = '0;
			end
			head = '0;
			tail = IDX_W'(NBLK - 1);
			n_free = NBLK;
			errors = 0;
		endfunction

		function void unlink(logic [IDX_W-1:0] id);
			logic [IDX_W-1:0] p, n;
			p = prev_link[id];
			n = next_link[id];
			if (id == head) head = n;
			else next_link[p] = n;
			if (id == tail) tail = p;
			else prev_link[n] = p;
			if (n_free > 0) n_free--;
			is_free[id] = 0;
		endfunction

		function void link_at_head(logic [IDX_W-1:0] id);
			if (n_free == 0) begin
				head = id;
				tail = id;
			end else begin
				next_link[id] = head;
				prev_link[head] = id;
				head = id;
			end
			prev_link[id] = '0;
			n_free++;
			is_free[id] = 1;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
				logic [FHASH_W-1:0] hv);
			pool_result_t r;
			logic [IDX_W-1:0] id;
			r = '0;
			r.status = ST_OK;
			if (kind == K_ALLOC) begin
				if (n_free == 0) r.status = ST_EMPTY;
				else begin
					id = tail;
					unlink(id);
					refcnt[id] = 1;
					if (tag[id] != 0) begin
						r.ev_valid = 1;
						r.ev_hash = tag[id];
						tag[id] = '0;
					end
					r.granted = id;
				end
			end else if (kind == K_ADD_REF) begin
				if (refcnt[idx] >= REF_MAX) r.status = ST_SATURATED;
				else refcnt[idx]++;
			end else if (kind == K_RELEASE) begin
				if (refcnt[idx] == 0) r.status = ST_UNDERFLOW;
				else begin
					refcnt[idx]--;
					if (refcnt[idx] == 0 && !is_free[idx]) begin
						link_at_head(idx);
						r.became_free = 1;
					end
				end
			end else if (kind == K_TAKE) begin
				if (!is_free[idx]) r.status = ST_NOT_FREE;
				else begin
					unlink(idx);
					refcnt[idx] = 1;
				end
			end else if (kind == K_SET_HASH) begin
				tag[idx] = hv;
			end
			pending = {pending, r};
		endfunction

		function void check_result(logic [M_DATA_W-1:0] data, logic [STAT_W-1:0] st);
			pool_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $realtime, st, data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, e.status, st);
				errors++;
			end
			if (data[M_GRANT_LO +: IDX_W] !== e.granted) begin
				$display("%0t: granted_block exp %0d got %0d", $realtime, e.granted,
					data[M_GRANT_LO +: IDX_W]);
				errors++;
			end
			if (data[M_EVV_BIT] !== e.ev_valid) begin
				$display("%0t: evicted_valid exp %0b got %0b", $realtime, e.ev_valid,
					data[M_EVV_BIT]);
				errors++;
			end
			if (data[M_EVH_LO +: FHASH_W] !== e.ev_hash) begin
				$display("%0t: evicted_hash exp %h got %h", $realtime, e.ev_hash,
					data[M_EVH_LO +: FHASH_W]);
				errors++;
			end
			if (data[M_FREE_BIT] !== e.became_free) begin
				$display("%0t: became_free exp %0b got %0b", $realtime, e.became_free,
					data[M_FREE_BIT]);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;  // block_index, hash_value
	logic [KIND_W-1:0]   s_axis_tuser;  // kind
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;  // granted_block, evicted_valid, evicted_hash, became_free
	logic [STAT_W-1:0]   m_axis_tuser;  // status

	pool_scoreboard sb;
	int idle_cycles;
	bit drain_done;

	refcounted_block_allocator_lru u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// hold each transaction until accepted, then note it; drop valid only for a gap
	task automatic send(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
			logic [FHASH_W-1:0] hv);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {{(S_DATA_W - IDX_W - FHASH_W){1'b0}}, hv, idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(kind, idx, hv);
	endtask

	function automatic logic [FHASH_W-1:0] rand_hash();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// random results stall
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (m_axis_tvalid && m_axis_tready) m_axis_tready <= (gap_len() == 0);
		else if (!m_axis_tready) m_axis_tready <= ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT && !drain_done) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int k, id;
		sb = new();
		idle_cycles = 0;
		drain_done = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		idle_cycles = 0;

		// directed: allocate with hash eviction, extremes, error cases
		send(K_SET_HASH, 10'd1023, '1);
		send(K_ALLOC, 10'd0, '0);
		send(K_SET_HASH, 10'd1022, 64'h1);
		send(K_ALLOC, 10'd511, '0);
		send(K_RELEASE, 10'd0, '0);
		send(K_RELEASE, 10'd1023, '0);
		send(K_RELEASE, 10'd1023, '0);
		send(K_TAKE, 10'd1023, '0);
		send(K_TAKE, 10'd1021, '0);
		send(K_TAKE, 10'd1021, '0);
		send(K_ADD_REF, 10'd5, '0);
		send(K_RELEASE, 10'd5, '0);
		send(K_SET_HASH, 10'd0, {$urandom, $urandom});
		send(K_TAKE, 10'd0, '0);
		send(K_RELEASE, 10'd0, '0);
		send(3'd5, 10'd3, '1);
		send(3'd6, 10'd3, '0);
		send(3'd7, 10'd3, '0);
		send(K_ADD_REF, 10'd700, '0);
		send(K_RELEASE, 10'd700, '0);
		send(K_ADD_REF, 10'd700, '0);

		// random mix weighted toward valid operations
		for (int i = 0; i < 680; i++) begin
			k = $urandom_range(0, 99);
			id = $urandom_range(0, 1023);
			if (k < 30) send(K_ALLOC, IDX_W'($urandom), '0);
			else if (k < 45) send(K_ADD_REF, IDX_W'(id), '0);
			else if (k < 70)
				send(K_RELEASE, IDX_W'($urandom_range(0, 1) ? id : $urandom_range(0, 15)), '0);
			else if (k < 80) send(K_TAKE, IDX_W'(id), '0);
			else if (k < 97) send(K_SET_HASH, IDX_W'(id), rand_hash());
			else send(KIND_W'($urandom_range(5, 7)), IDX_W'(id), rand_hash());
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		drain_done = 1;
		if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rba_pkg.sv
rtl/rba_ram.sv
rtl/rba_ctrl.sv
rtl/rba_dp.sv
rtl/refcounted_block_allocator_lru.sv
rtl/rba_checker.sv
tb/refcounted_block_allocator_lru_test.sv
